// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define CSPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CSPT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cspt_pkg.sv
package cspt_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int ID_WIDTH_DEF   = 16;

    localparam int CONN_ID_W    = 16;
    localparam int SLOT_FIELD_W = 6;
    localparam int STATUS_W     = 2;
    localparam int IDX_EXT_W    = 9;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = STATUS_W;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH    = 2'd0,
        ST_NEW      = 2'd1,
        ST_FULL     = 2'd2,
        ST_RELEASED = 2'd3
    } status_t;

endpackage

// File: rtl/core/connection_slot_probe_table_top.sv
// Channel | Ports             | tdata (low bit up)             | tuser
// --------+-------------------+--------------------------------+-------------
// input   | s_tvalid/s_tready | conn_id[15:0], release_slot    | opcode
// result  | m_tvalid/m_tready | slot[5:0], zero pad            | status[1:0]
//
// Release and id zero: straight from idle to the response state, then the output register.
// Acquire: a remainder step (reciprocal multiply, skipped when SLOT_COUNT is a power
// of two), then a table read and up to SLOT_COUNT probes, then the response state;
// the single table read port sets one probe per cycle.
// s_tready is high only while idle; a result waits in the output register under stall.
// aresetn is synchronous; reset marks all slots free through per-slot valid bits.
module connection_slot_probe_table_top
    import cspt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // conn_id[15:0], release_slot[21:16], pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // opcode[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // slot[5:0], pad
    output logic [M_TUSER_W-1:0] m_tuser    // status[1:0]
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int KEY_W  = (ID_WIDTH < CONN_ID_W) ? ID_WIDTH : CONN_ID_W;
    localparam int PROD_W = 2 * KEY_W + 1;
    localparam int RCP_SH = KEY_W + IDX_W;
    localparam bit POW2   = ((1 << IDX_W) == SLOT_COUNT);
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [IDX_W:0]       CNT_EXT  = (IDX_W + 1)'(SLOT_COUNT);
    localparam logic [IDX_EXT_W-1:0] CNT_RS   = IDX_EXT_W'(SLOT_COUNT);
    // ceil(2^RCP_SH / SLOT_COUNT): exact quotient for every KEY_W-bit key
    localparam logic [KEY_W:0]       RCP      = (KEY_W + 1)'(
        ((64'd1 << RCP_SH) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOD   = 5'b00010,
        S_LOAD  = 5'b00100,
        S_PROBE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [KEY_W-1:0]        quo_reg, quo_next;
    logic [IDX_W-1:0]        probe_reg, probe_next;
    logic [IDX_W-1:0]        cmp_reg, cmp_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [SLOT_FIELD_W-1:0] res_slot_reg, res_slot_next;
    status_t                 res_stat_reg, res_stat_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SLOT_FIELD_W-1:0] m_slot_reg, m_slot_next;
    status_t                 m_stat_reg, m_stat_next;

    logic [KEY_W-1:0]        mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   vld_reg;
    logic [KEY_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;

    opcode_t                 in_op;
    logic [KEY_W-1:0]        in_key;
    logic [SLOT_FIELD_W-1:0] in_rs;
    logic [IDX_EXT_W-1:0]    rs_ext;
    logic                    mem_we;
    logic                    vld_clr;
    logic [PROD_W-1:0]       quo_prod;
    logic [IDX_W-1:0]        mod_rem;
    logic [KEY_W-1:0]        owner;
    logic [IDX_W-1:0]        probe_inc;
    logic [IDX_EXT_W-1:0]    cmp_ext;
    logic                    out_load;

    assign in_op  = opcode_t'(s_tuser[0]);
    assign in_key = s_tdata[KEY_W-1:0];
    assign in_rs  = s_tdata[CONN_ID_W +: SLOT_FIELD_W];
    assign rs_ext = IDX_EXT_W'(in_rs);

    // remainder fits in IDX_W bits, so only the low bits of key - q * N matter
    assign quo_prod = PROD_W'(in_key) * PROD_W'(RCP);
    assign mod_rem  = key_reg[IDX_W-1:0] - IDX_W'(quo_reg * CNT_EXT);

    assign owner     = rd_vld_reg ? rd_data_reg : '0;
    assign probe_inc = (probe_reg == LAST_IDX) ? '0 : (probe_reg + 1'b1);
    assign cmp_ext   = IDX_EXT_W'(cmp_reg);

    assign out_load = (state_reg == S_RESP) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        quo_next      = quo_reg;
        probe_next    = probe_reg;
        cmp_next      = cmp_reg;
        step_next     = step_reg;
        res_slot_next = res_slot_reg;
        res_stat_next = res_stat_reg;
        mem_we        = 1'b0;
        vld_clr       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_op == OP_RELEASE) begin
                        vld_clr       = (rs_ext < CNT_RS);
                        res_slot_next = in_rs;
                        res_stat_next = ST_RELEASED;
                        state_next    = S_RESP;
                    end else if (in_key == '0) begin
                        res_slot_next = '0;
                        res_stat_next = ST_FULL;
                        state_next    = S_RESP;
                    end else begin
                        key_next = in_key;
                        if (POW2) begin
                            probe_next = in_key[IDX_W-1:0];
                            state_next = S_LOAD;
                        end else begin
                            quo_next   = KEY_W'(quo_prod >> RCP_SH);
                            state_next = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                probe_next = mod_rem;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmp_next   = probe_reg;
                probe_next = probe_inc;
                step_next  = '0;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                priority if (owner == key_reg) begin
                    res_slot_next = cmp_ext[SLOT_FIELD_W-1:0];
                    res_stat_next = ST_MATCH;
                    state_next    = S_RESP;
                end else if (owner == '0) begin
                    mem_we        = 1'b1;
                    res_slot_next = cmp_ext[SLOT_FIELD_W-1:0];
                    res_stat_next = ST_NEW;
                    state_next    = S_RESP;
                end else if (step_reg == LAST_IDX) begin
                    res_slot_next = '0;
                    res_stat_next = ST_FULL;
                    state_next    = S_RESP;
                end else begin
                    step_next  = step_reg + 1'b1;
                    cmp_next   = probe_reg;
                    probe_next = probe_inc;
                end
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_slot_next   = m_slot_reg;
        m_stat_next   = m_stat_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_slot_next   = res_slot_reg;
            m_stat_next   = res_stat_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        quo_reg      <= quo_next;
        probe_reg    <= probe_next;
        cmp_reg      <= cmp_next;
        step_reg     <= step_next;
        res_slot_reg <= res_slot_next;
        res_stat_reg <= res_stat_next;
        m_slot_reg   <= m_slot_next;
        m_stat_reg   <= m_stat_next;
    end

    // slot table: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cmp_reg] <= key_reg;
        end
        rd_data_reg <= mem[probe_reg];
        rd_vld_reg  <= vld_reg[probe_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_we) begin
            vld_reg[cmp_reg] <= 1'b1;
        end else if (vld_clr) begin
            vld_reg[rs_ext[IDX_W-1:0]] <= 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_slot_reg);
    assign m_tuser  = m_stat_reg;

endmodule

// File: rtl/core/cspt_checker.sv
`include "assert_macros.svh"

module cspt_checker
    import cspt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    `CSPT_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && s_tready, "reset state wrong")

    `CSPT_ASSERT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    `CSPT_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `CSPT_ASSERT(a_full_slot_zero, aclk, aresetn, m_tvalid && m_tuser == ST_FULL |-> m_tdata == '0, "full result with nonzero slot")

endmodule

bind connection_slot_probe_table_top cspt_checker u_cspt_checker (.*);
